// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the segment intersection test.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk_i, rst_ni, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk_i, rst_ni, ante, cons)
`define ASSERT_NEXT(label, clk_i, rst_ni, ante, cons)

`endif

`endif

// ===== src/sit_pkg.sv =====
// Package for the segment intersection test: default width, pipeline depth,
// index constants for coordinates and differences, and range, bound and lane counts. No dependencies.
`default_nettype none

package sit_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Register stages from the input word to the output register.
  localparam int STAGES = 7;

  // Coordinate slots in the first stage.
  localparam int NUM_COORDS = 8;
  localparam int CI_AX = 0;
  localparam int CI_AY = 1;
  localparam int CI_BX = 2;
  localparam int CI_BY = 3;
  localparam int CI_CX = 4;
  localparam int CI_CY = 5;
  localparam int CI_DX = 6;
  localparam int CI_DY = 7;

  // Direction vector components.
  localparam int NUM_DIFFS = 4;
  localparam int DI_XA = 0;
  localparam int DI_YA = 1;
  localparam int DI_XB = 2;
  localparam int DI_YB = 3;

  // Four ranges (x of A, x of B, y of A, y of B), each a low and a high bound.
  localparam int NUM_RANGES = 4;
  localparam int NUM_BOUNDS = 2 * NUM_RANGES;

  // Multiplier lanes: four numerator products, then one per bound.
  localparam int NUM_NUM_LANES = 4;
  localparam int NUM_LANES = NUM_NUM_LANES + NUM_BOUNDS;

endpackage

`default_nettype wire

// ===== src/sit_in_if.sv =====
// Input channel of the segment intersection test: one word is a pair of segments.
// Depends on sit_pkg for the default coordinate width.
`default_nettype none

interface sit_in_if #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by_coord;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;
  logic signed [COORD_WIDTH-1:0] dx;
  logic signed [COORD_WIDTH-1:0] dy;

  modport source (
    output valid, ax, ay, bx, by_coord, cx, cy, dx, dy,
    input  ready
  );

  modport sink (
    input  valid, ax, ay, bx, by_coord, cx, cy, dx, dy,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/sit_out_if.sv =====
// Result channel of the segment intersection test: one word holds both flags.
// No dependencies.
`default_nettype none

interface sit_out_if ();
  logic valid;
  logic ready;
  logic intersects;
  logic parallel;

  modport source (
    output valid, intersects, parallel,
    input  ready
  );

  modport sink (
    input  valid, intersects, parallel,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/segment_intersection_test.sv =====
// Segment intersection test: one pair of segments accepted per cycle unless the
// result word is stalled. The whole pipeline advances together and holds while
// a finished word waits at the output register; the twelve split multiplier
// lanes of stage four set the depth. Reset clears the valid bits only.
`default_nettype none
`include "assert_macros.svh"

module segment_intersection_test #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  sit_in_if.sink     in_seg,
  sit_out_if.source  out_res
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;        // coordinate and difference width
  localparam int PW = 2 * DW;       // product of two of those
  localparam int XW = PW + 1;       // determinant and cross terms
  localparam int LW = XW / 2;       // low slice of a split wide operand
  localparam int HW = XW - LW;      // high slice
  localparam int MW = XW + DW;      // wide times narrow product
  localparam int NW = MW + 1;       // numerators

  localparam int NC = sit_pkg::NUM_COORDS;
  localparam int ND = sit_pkg::NUM_DIFFS;
  localparam int NR = sit_pkg::NUM_RANGES;
  localparam int NB = sit_pkg::NUM_BOUNDS;
  localparam int NL = sit_pkg::NUM_LANES;
  localparam int NS = sit_pkg::STAGES;

  logic          adv;
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;

  // The whole pipeline moves unless the output word is stalled.
  assign adv          = !vld_r[NS-1] || out_res.ready;
  assign in_seg.ready = adv;
  assign vld_nxt      = {vld_r[NS-2:0], in_seg.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: sign-extended coordinates and direction vectors.
  logic signed [DW-1:0] crd_nxt  [NC];
  logic signed [DW-1:0] crd_r    [NC];
  logic signed [DW-1:0] dif_nxt  [ND];
  logic signed [DW-1:0] dif1_r   [ND];

  always_comb begin
    crd_nxt[sit_pkg::CI_AX] = DW'(in_seg.ax);
    crd_nxt[sit_pkg::CI_AY] = DW'(in_seg.ay);
    crd_nxt[sit_pkg::CI_BX] = DW'(in_seg.bx);
    crd_nxt[sit_pkg::CI_BY] = DW'(in_seg.by_coord);
    crd_nxt[sit_pkg::CI_CX] = DW'(in_seg.cx);
    crd_nxt[sit_pkg::CI_CY] = DW'(in_seg.cy);
    crd_nxt[sit_pkg::CI_DX] = DW'(in_seg.dx);
    crd_nxt[sit_pkg::CI_DY] = DW'(in_seg.dy);
    dif_nxt[sit_pkg::DI_XA] = crd_nxt[sit_pkg::CI_AX] - crd_nxt[sit_pkg::CI_BX];
    dif_nxt[sit_pkg::DI_YA] = crd_nxt[sit_pkg::CI_AY] - crd_nxt[sit_pkg::CI_BY];
    dif_nxt[sit_pkg::DI_XB] = crd_nxt[sit_pkg::CI_CX] - crd_nxt[sit_pkg::CI_DX];
    dif_nxt[sit_pkg::DI_YB] = crd_nxt[sit_pkg::CI_CY] - crd_nxt[sit_pkg::CI_DY];
  end

  // Stage 2: determinant and cross products, plus the bounding boxes.
  logic signed [PW-1:0] prd_nxt [6];
  logic signed [PW-1:0] prd_r   [6];
  logic signed [DW-1:0] bnd_nxt [NB];
  logic signed [DW-1:0] bnd2_r  [NB];
  logic signed [DW-1:0] dif2_r  [ND];
  logic signed [DW-1:0] rp      [NR];
  logic signed [DW-1:0] rq      [NR];

  always_comb begin
    prd_nxt[0] = dif1_r[sit_pkg::DI_XA] * dif1_r[sit_pkg::DI_YB];
    prd_nxt[1] = dif1_r[sit_pkg::DI_YA] * dif1_r[sit_pkg::DI_XB];
    prd_nxt[2] = crd_r[sit_pkg::CI_AX] * crd_r[sit_pkg::CI_BY];
    prd_nxt[3] = crd_r[sit_pkg::CI_AY] * crd_r[sit_pkg::CI_BX];
    prd_nxt[4] = crd_r[sit_pkg::CI_CX] * crd_r[sit_pkg::CI_DY];
    prd_nxt[5] = crd_r[sit_pkg::CI_CY] * crd_r[sit_pkg::CI_DX];
    // Ranges: x of A, x of B, y of A, y of B.
    rp[0] = crd_r[sit_pkg::CI_AX];
    rq[0] = crd_r[sit_pkg::CI_BX];
    rp[1] = crd_r[sit_pkg::CI_CX];
    rq[1] = crd_r[sit_pkg::CI_DX];
    rp[2] = crd_r[sit_pkg::CI_AY];
    rq[2] = crd_r[sit_pkg::CI_BY];
    rp[3] = crd_r[sit_pkg::CI_CY];
    rq[3] = crd_r[sit_pkg::CI_DY];
    for (int r = 0; r < NR; r++) begin
      bnd_nxt[2*r]   = (rp[r] <= rq[r]) ? rp[r] : rq[r];
      bnd_nxt[2*r+1] = (rp[r] <= rq[r]) ? rq[r] : rp[r];
    end
  end

  // Stage 3: determinant and the two line cross terms.
  logic signed [XW-1:0] det_nxt;
  logic signed [XW-1:0] cra_nxt;
  logic signed [XW-1:0] crb_nxt;
  logic signed [XW-1:0] det_r;
  logic signed [XW-1:0] cra_r;
  logic signed [XW-1:0] crb_r;
  logic signed [DW-1:0] bnd3_r [NB];
  logic signed [DW-1:0] dif3_r [ND];

  assign det_nxt = XW'(prd_r[0]) - XW'(prd_r[1]);
  assign cra_nxt = XW'(prd_r[2]) - XW'(prd_r[3]);
  assign crb_nxt = XW'(prd_r[4]) - XW'(prd_r[5]);

  // Stage 4: each wide-by-narrow product as two partial products.
  logic signed [XW-1:0]      wop     [NL];
  logic signed [DW-1:0]      nop     [NL];
  logic signed [HW+DW-1:0]   pph_nxt [NL];
  logic signed [LW+DW:0]     ppl_nxt [NL];
  logic signed [HW+DW-1:0]   pph_r   [NL];
  logic signed [LW+DW:0]     ppl_r   [NL];
  logic                      zero4_r;
  logic                      neg4_r;

  always_comb begin
    wop[0] = cra_r;
    nop[0] = dif3_r[sit_pkg::DI_XB];
    wop[1] = crb_r;
    nop[1] = dif3_r[sit_pkg::DI_XA];
    wop[2] = cra_r;
    nop[2] = dif3_r[sit_pkg::DI_YB];
    wop[3] = crb_r;
    nop[3] = dif3_r[sit_pkg::DI_YA];
    for (int i = 0; i < NB; i++) begin
      wop[sit_pkg::NUM_NUM_LANES + i] = det_r;
      nop[sit_pkg::NUM_NUM_LANES + i] = bnd3_r[i];
    end
    for (int k = 0; k < NL; k++) begin
      pph_nxt[k] = $signed(wop[k][XW-1:LW]) * nop[k];
      ppl_nxt[k] = $signed({1'b0, wop[k][LW-1:0]}) * nop[k];
    end
  end

  // Stage 5: recombine the partial products.
  logic signed [MW-1:0] ful_nxt [NL];
  logic signed [MW-1:0] ful_r   [NL];
  logic                 zero5_r;
  logic                 neg5_r;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      ful_nxt[k] = $signed({pph_r[k], {LW{1'b0}}}) + MW'(ppl_r[k]);
    end
  end

  // Stage 6: numerators of the crossing point.
  logic signed [NW-1:0] nx_r;
  logic signed [NW-1:0] ny_r;
  logic signed [MW-1:0] bp_r [NB];
  logic                 zero6_r;
  logic                 neg6_r;

  // Stage 7: range checks into the output register. With a negative
  // determinant the scaled bounds swap roles, so the compares flip.
  logic signed [NW-1:0] num  [NR];
  logic signed [NW-1:0] blo  [NR];
  logic signed [NW-1:0] bhi  [NR];
  logic [NR-1:0]        ok;
  logic                 int_nxt;
  logic                 int_r;
  logic                 par_r;

  always_comb begin
    for (int r = 0; r < NR; r++) begin
      num[r] = (r < 2) ? nx_r : ny_r;
      blo[r] = NW'(bp_r[2*r]);
      bhi[r] = NW'(bp_r[2*r+1]);
      if (neg6_r) begin
        ok[r] = (num[r] <= blo[r]) && (bhi[r] <= num[r]);
      end else begin
        ok[r] = (blo[r] <= num[r]) && (num[r] <= bhi[r]);
      end
    end
    int_nxt = !zero6_r && (&ok);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crd_r   <= crd_nxt;
      dif1_r  <= dif_nxt;

      prd_r   <= prd_nxt;
      bnd2_r  <= bnd_nxt;
      dif2_r  <= dif1_r;

      det_r   <= det_nxt;
      cra_r   <= cra_nxt;
      crb_r   <= crb_nxt;
      bnd3_r  <= bnd2_r;
      dif3_r  <= dif2_r;

      pph_r   <= pph_nxt;
      ppl_r   <= ppl_nxt;
      zero4_r <= (det_r == '0);
      neg4_r  <= det_r[XW-1];

      ful_r   <= ful_nxt;
      zero5_r <= zero4_r;
      neg5_r  <= neg4_r;

      nx_r    <= NW'(ful_r[0]) - NW'(ful_r[1]);
      ny_r    <= NW'(ful_r[2]) - NW'(ful_r[3]);
      for (int i = 0; i < NB; i++) begin
        bp_r[i] <= ful_r[sit_pkg::NUM_NUM_LANES + i];
      end
      zero6_r <= zero5_r;
      neg6_r  <= neg5_r;

      int_r   <= int_nxt;
      par_r   <= zero6_r;
    end
  end

  assign out_res.valid      = vld_r[NS-1];
  assign out_res.intersects = int_r;
  assign out_res.parallel   = par_r;

  // An accepted word shows up in the first stage.
  `ASSERT_NEXT(a_enter, clk, rst_n, in_seg.valid && in_seg.ready, vld_r[0])
  // A word in the last internal stage reaches the output when the pipe moves.
  `ASSERT_NEXT(a_reach_out, clk, rst_n, vld_r[NS-2] && adv, out_res.valid)
  // A stall freezes every valid bit.
  `ASSERT_NEXT(a_hold, clk, rst_n, !adv, $stable(vld_r))
  // A zero determinant always leaves as parallel and never as a hit.
  `ASSERT_NEXT(a_par, clk, rst_n, vld_r[NS-2] && adv && zero6_r,
               out_res.parallel && !out_res.intersects)
  // Parallel and a hit never come together.
  `ASSERT_IMPL(a_excl, clk, rst_n, out_res.valid, !(out_res.parallel && out_res.intersects))

endmodule

`default_nettype wire
